// ----- rtl/rrl_pkg.sv -----
// Shared types and constants for the ranked result list.
package rrl_pkg;

  localparam int ID_W    = 32;
  localparam int SCORE_W = 32;
  localparam int RANK_W  = 6;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic                      insert;
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           doc_id;
    logic [RANK_W-1:0]         rank_index;
  } bcast_t;

endpackage

// ----- rtl/rrl_cell.sv -----
// One ranked slot: holds a pair and shifts or takes the new pair on an insert.
module rrl_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7,
  parameter int CMP_W = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rrl_pkg::bcast_t                   bcast,
  input  logic [CNT_W-1:0]                  held_count,
  input  logic                              left_after,
  input  logic signed [rrl_pkg::SCORE_W-1:0] left_score,
  input  logic [rrl_pkg::ID_W-1:0]          left_id,
  output logic                              goes_after,
  output logic signed [rrl_pkg::SCORE_W-1:0] score,
  output logic [rrl_pkg::ID_W-1:0]          doc_id,
  output logic [rrl_pkg::ID_W+rrl_pkg::SCORE_W-1:0] rd_word
);
  import rrl_pkg::*;

  logic valid;
  logic match;

  assign valid      = CNT_W'(INDEX) < held_count;
  assign goes_after = valid && (score >= bcast.score);
  assign match      = CMP_W'(INDEX) == CMP_W'(bcast.rank_index);
  assign rd_word    = match ? {score, doc_id} : '0;

  always_ff @(posedge clk) begin
    if (bcast.insert && !goes_after) begin
      if (left_after) begin
        score  <= bcast.score;
        doc_id <= bcast.doc_id;
      end else begin
        score  <= left_score;
        doc_id <= left_id;
      end
    end
  end

  // Held pairs are in non-increasing score order along the row.
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (INDEX > 0 && valid) |-> (left_score >= score))
    else $error("ranked order broken");

endmodule

// ----- rtl/ranked_result_list.sv -----
// Top level of the ranked result list: handshake, count and the row of cells.
//
//  channel | direction | fields (lowest bit first)
//  s_*     | in        | action[1:0] doc_id[33:2] score[65:34] rank_index[71:66]
//  m_*     | out       | doc_id_out[31:0] score_out[63:32] status[65:64] entry_count[72:66]
//
// Each item is handled combinationally by the cell row, with the result registered
// and shown on the following cycle; one item per cycle is sustained while results
// are taken. The insert compare in every cell against the broadcast score sets that rate.
// Reset clears the count and the output valid; held pairs are not cleared.
// A result that is not taken holds the input side until it is taken.
module ranked_result_list #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // action, doc_id, score, rank_index
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // doc_id_out, score_out, status, entry_count, zero pad
);
  import rrl_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;

  action_t                   action;
  logic [ID_W-1:0]           in_id;
  logic signed [SCORE_W-1:0] in_score;
  logic [RANK_W-1:0]         rank_index;
  logic                      accept;
  logic                      insert_now;
  bcast_t                    bcast;

  logic [CW-1:0]             held_count;
  logic [CW-1:0]             held_count_next;
  status_t                   status_next;
  logic [ID_W-1:0]           id_next;
  logic signed [SCORE_W-1:0] score_next;

  logic [ID_W-1:0]           doc_id_out;
  logic signed [SCORE_W-1:0] score_out;
  status_t                   status;
  logic [COUNT_OUT_W-1:0]    entry_count;

  logic                      cell_after [CAPACITY];
  logic signed [SCORE_W-1:0] cell_score [CAPACITY];
  logic [ID_W-1:0]           cell_id    [CAPACITY];
  logic [ID_W+SCORE_W-1:0]   cell_rd    [CAPACITY];
  logic [ID_W+SCORE_W-1:0]   rd_any;

  assign action     = action_t'(s_tdata[1:0]);
  assign in_id      = s_tdata[33:2];
  assign in_score   = s_tdata[65:34];
  assign rank_index = s_tdata[71:66];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign bcast.insert     = insert_now;
  assign bcast.score      = in_score;
  assign bcast.doc_id     = in_id;
  assign bcast.rank_index = rank_index;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      rrl_cell #(.INDEX(i), .CNT_W(CW), .CMP_W(CMPW)) u_cell (
        .clk(clk), .rst(rst), .bcast(bcast), .held_count(held_count),
        .left_after(1'b1), .left_score('0), .left_id('0),
        .goes_after(cell_after[i]), .score(cell_score[i]), .doc_id(cell_id[i]),
        .rd_word(cell_rd[i])
      );
    end else begin : g_body
      rrl_cell #(.INDEX(i), .CNT_W(CW), .CMP_W(CMPW)) u_cell (
        .clk(clk), .rst(rst), .bcast(bcast), .held_count(held_count),
        .left_after(cell_after[i-1]), .left_score(cell_score[i-1]),
        .left_id(cell_id[i-1]),
        .goes_after(cell_after[i]), .score(cell_score[i]), .doc_id(cell_id[i]),
        .rd_word(cell_rd[i])
      );
    end
  end

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  always_comb begin
    insert_now      = 1'b0;
    held_count_next = held_count;
    status_next     = ST_OK;
    id_next         = '0;
    score_next      = '0;
    case (action)
      ACT_ADD: begin
        if (held_count >= CW'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          insert_now      = accept;
          held_count_next = held_count + CW'(1);
        end
      end
      ACT_READ: begin
        if (CMPW'(rank_index) < CMPW'(held_count)) begin
          id_next    = rd_any[ID_W-1:0];
          score_next = rd_any[ID_W+SCORE_W-1:ID_W];
        end else begin
          status_next = ST_RANGE;
        end
      end
      ACT_CLEAR: begin
        held_count_next = '0;
      end
      default: begin
        held_count_next = held_count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        held_count <= held_count_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      doc_id_out  <= id_next;
      score_out   <= score_next;
      status      <= status_next;
      entry_count <= COUNT_OUT_W'(held_count_next);
    end
  end

  assign m_tdata = {7'd0, entry_count, status, score_out, doc_id_out};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(CAPACITY))
    else $error("count above capacity");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_ADD && held_count < CW'(CAPACITY))
      |=> (held_count == $past(held_count) + CW'(1)))
    else $error("add did not grow the list");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == ST_FULL) |-> (held_count == CW'(CAPACITY)))
    else $error("full reported below capacity");

  a_count_shown: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (entry_count == COUNT_OUT_W'(held_count)))
    else $error("shown count differs from held count");

endmodule
